// ----- rtl/deblocking_edge_segment_filter_assert.svh -----
// Assertion macros shared by the deblocking edge segment filter RTL.
`ifndef DEBLOCKING_EDGE_SEGMENT_FILTER_ASSERT_SVH
`define DEBLOCKING_EDGE_SEGMENT_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define DESF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DESF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DESF_ASSERT(lbl, prop, msg)
`define DESF_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- rtl/desf_pkg.sv -----
// Types, constants and helper functions of the deblocking edge segment filter.
package desf_pkg;

  localparam int NumLines  = 4;
  localparam int PixW      = 8;
  localparam int LineInW   = 6 * PixW;
  localparam int LineOutW  = 4 * PixW;
  localparam int MaskW     = NumLines;
  localparam int BetaW     = 7;
  localparam int TcW       = 5;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = BetaW;
  localparam int InDataW   = NumLines * LineInW;
  localparam int OutBitsW  = NumLines * LineOutW + MaskW;
  localparam int OutDataW  = ((OutBitsW + 7) / 8) * 8;

  // Filter tap weights and rounding offsets.
  localparam int LumaTapInner  = 9;
  localparam int LumaTapOuter  = 3;
  localparam int LumaRound     = 8;
  localparam int ChromaRound   = 4;
  localparam int EdgeTcScale   = 10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BETA   = 2'd0,
    CFG_TC     = 2'd1,
    CFG_CHROMA = 2'd2
  } cfg_idx_e;

  // Segment decision from the activity test on lines 0 and 3.
  typedef struct packed {
    logic act_ok;
    logic ep;
    logic eq;
  } desf_act_t;

  // Per-segment control handed to every lane for its second stage.
  typedef struct packed {
    logic      on;
    logic      chroma;
    desf_act_t act;
  } desf_ctrl_t;

  function automatic logic [PixW-1:0] clamp_pix(input logic signed [11:0] v);
    logic [PixW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > 12'sd255) begin
      r = '1;
    end else begin
      r = v[PixW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [11:0] clip_sym(input logic signed [11:0] v,
                                                  input logic [TcW-1:0] lim);
    logic signed [11:0] l;
    logic signed [11:0] r;
    l = $signed({7'd0, lim});
    if (v > l) begin
      r = l;
    end else if (v < -l) begin
      r = -l;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- rtl/desf_act.sv -----
// Second-difference activity test of a segment on lines 0 and 3.
module desf_act
  import desf_pkg::*;
(
  input  logic [LineInW-1:0] line0_i,
  input  logic [LineInW-1:0] line3_i,
  input  logic [BetaW-1:0]   beta_i,
  output desf_act_t          act_o
);

  // Absolute second difference a - 2b + c of three pixels.
  function automatic logic [9:0] sec_diff(input logic [PixW-1:0] a,
                                          input logic [PixW-1:0] b,
                                          input logic [PixW-1:0] c);
    logic signed [10:0] s;
    s = $signed({3'd0, a}) - $signed({2'd0, b, 1'b0}) + $signed({3'd0, c});
    return s < 0 ? 10'(-s) : 10'(s);
  endfunction

  logic [9:0]  dp0, dq0, dp3, dq3;
  logic [10:0] sum_p, sum_q;
  logic [11:0] sum_all;
  logic [4:0]  side;
  logic [7:0]  beta_ext;

  always_comb begin
    dp0      = sec_diff(line0_i[47:40], line0_i[39:32], line0_i[31:24]);
    dq0      = sec_diff(line0_i[7:0],   line0_i[15:8],  line0_i[23:16]);
    dp3      = sec_diff(line3_i[47:40], line3_i[39:32], line3_i[31:24]);
    dq3      = sec_diff(line3_i[7:0],   line3_i[15:8],  line3_i[23:16]);
    sum_p    = {1'b0, dp0} + {1'b0, dp3};
    sum_q    = {1'b0, dq0} + {1'b0, dq3};
    sum_all  = {1'b0, sum_p} + {1'b0, sum_q};
    beta_ext = {1'b0, beta_i} + {2'b0, beta_i[BetaW-1:1]};
    side     = beta_ext[7:3];
    act_o.act_ok = sum_all < {5'd0, beta_i};
    act_o.ep     = sum_p < {6'd0, side};
    act_o.eq     = sum_q < {6'd0, side};
  end

endmodule

// ----- rtl/desf_lane.sv -----
// One line of the segment: delta computation, then clipped pixel corrections.
module desf_lane
  import desf_pkg::*;
(
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [LineInW-1:0]  line_i,
  input  logic [TcW-1:0]      tc_i,
  input  logic                chroma_i,
  input  desf_ctrl_t          ctrl_i,
  output logic [LineOutW-1:0] line_o,
  output logic                changed_o
);

  logic [PixW-1:0] p2, p1, p0, q0, q1, q2;
  logic signed [12:0] dqp, dpq1, sum_chroma, sum_luma, sum_sel;
  logic signed [9:0]  d_raw;
  logic [8:0]         d_abs;
  logic [8:0]         tc_edge;
  logic [8:0]         avg_p, avg_q;
  logic signed [9:0]  side_p, side_q;

  logic [PixW-1:0]   p1_q, p0_q, q0_q, q1_q;
  logic signed [9:0] d_q, side_p_q, side_q_q;
  logic              big_q;

  logic signed [11:0] dc, adj_p, adj_q;
  logic [PixW-1:0]    p1n, p0n, q0n, q1n;
  logic               filt;

  // First stage: raw delta, edge test and side averages.
  always_comb begin
    {p2, p1, p0, q0, q1, q2} = line_i;
    dqp        = $signed({5'd0, q0}) - $signed({5'd0, p0});
    dpq1       = $signed({5'd0, p1}) - $signed({5'd0, q1});
    sum_chroma = (dqp <<< 2) + dpq1 + 13'(ChromaRound);
    sum_luma   = 13'(LumaTapInner) * dqp + 13'(LumaTapOuter) * dpq1 + 13'(LumaRound);
    sum_sel    = chroma_i ? (sum_chroma >>> 3) : (sum_luma >>> 4);
    d_raw      = sum_sel[9:0];
    d_abs      = d_raw < 0 ? 9'(-d_raw) : 9'(d_raw);
    tc_edge    = 9'(tc_i * 9'(EdgeTcScale));
    avg_p      = ({1'b0, p2} + {1'b0, p0} + 9'd1) >> 1;
    avg_q      = ({1'b0, q2} + {1'b0, q0} + 9'd1) >> 1;
    side_p     = $signed({2'd0, avg_p[7:0]}) - $signed({2'd0, p1});
    side_q     = $signed({2'd0, avg_q[7:0]}) - $signed({2'd0, q1});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q     <= p1;
      p0_q     <= p0;
      q0_q     <= q0;
      q1_q     <= q1;
      d_q      <= d_raw;
      big_q    <= d_abs >= tc_edge;
      side_p_q <= side_p;
      side_q_q <= side_q;
    end
  end

  // Second stage: clip the delta and apply it to the inner pixels.
  always_comb begin
    dc    = clip_sym(12'(d_q), tc_i);
    p0n   = clamp_pix($signed({4'd0, p0_q}) + dc);
    q0n   = clamp_pix($signed({4'd0, q0_q}) - dc);
    adj_p = clip_sym((12'(side_p_q) + dc) >>> 1, {1'b0, tc_i[TcW-1:1]});
    adj_q = clip_sym((12'(side_q_q) - dc) >>> 1, {1'b0, tc_i[TcW-1:1]});
    p1n   = clamp_pix($signed({4'd0, p1_q}) + adj_p);
    q1n   = clamp_pix($signed({4'd0, q1_q}) + adj_q);
    filt  = ctrl_i.on && (ctrl_i.chroma || (ctrl_i.act.act_ok && !big_q));
    line_o    = {p1_q, p0_q, q0_q, q1_q};
    changed_o = filt;
    if (filt) begin
      line_o[23:16] = p0n;
      line_o[15:8]  = q0n;
      if (!ctrl_i.chroma && ctrl_i.act.ep) begin
        line_o[31:24] = p1n;
      end
      if (!ctrl_i.chroma && ctrl_i.act.eq) begin
        line_o[7:0] = q1n;
      end
    end
  end

endmodule

// ----- rtl/deblocking_edge_segment_filter.sv -----
// Top level of the deblocking edge segment filter: config, lanes and output register.
//
//   Channel   Direction  Transfer when              Contents
//   s_axis    in         tvalid_i && tready_o       four lines of six pixels
//   m_axis    out        tvalid_o && tready_i       four filtered lines, changed mask
//   cfg       in         cfg_we_i                   beta, tc, chroma mode
//
// One segment is taken per clock cycle while the output is not stalled. A segment
// is registered first in the lane delta stage, then, through the correction stage,
// in the output register, from which it transfers out. The rate is set by this
// two-register pipeline, one lane per line working side by side.
// Reset clears the configuration registers to zero and empties the pipeline.
// A stall on the output freezes both stages; input is still taken while the
// first stage is empty or moves forward into a free output register.
`include "deblocking_edge_segment_filter_assert.svh"
module deblocking_edge_segment_filter
  import desf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Fields from bit 0 up: line_zero, line_one, line_two, line_three.
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // Fields from bit 0 up: out_line_zero, out_line_one, out_line_two,
  // out_line_three, changed_mask, then zero fill.
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [BetaW-1:0] beta_q;
  logic [TcW-1:0]   tc_q;
  logic             chroma_q;

  // Configuration writes; an index outside the register list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q   <= '0;
      tc_q     <= '0;
      chroma_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BETA:   beta_q   <= cfg_data_i[BetaW-1:0];
        CFG_TC:     tc_q     <= cfg_data_i[TcW-1:0];
        CFG_CHROMA: chroma_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline control. The output register advances whenever it is empty or
  // being taken; the first stage advances whenever it is empty or can move on.
  logic v1_q, m_valid_q;
  logic adv2, en1, load1;

  assign adv2            = !m_valid_q || m_axis_tready_i;
  assign en1             = !v1_q || adv2;
  assign load1           = en1 && s_axis_tvalid_i;
  assign s_axis_tready_o = en1;
  assign m_axis_tvalid_o = m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= s_axis_tvalid_i;
      end
      if (adv2) begin
        m_valid_q <= v1_q;
      end
    end
  end

  // Segment-wide decision, registered alongside the lanes' first stage.
  logic [LineInW-1:0] lines [NumLines];
  desf_act_t          act;
  desf_ctrl_t         ctrl1_q;

  always_comb begin
    for (int l = 0; l < NumLines; l++) begin
      lines[l] = s_axis_tdata_i[l*LineInW +: LineInW];
    end
  end

  desf_act u_act (
    .line0_i (lines[0]),
    .line3_i (lines[NumLines-1]),
    .beta_i  (beta_q),
    .act_o   (act)
  );

  always_ff @(posedge clk_i) begin
    if (load1) begin
      ctrl1_q.on     <= (beta_q != '0) && (tc_q != '0);
      ctrl1_q.chroma <= chroma_q;
      ctrl1_q.act    <= act;
    end
  end

  // One lane per line of the segment.
  logic [LineOutW-1:0] lane_out [NumLines];
  logic [MaskW-1:0]    lane_chg;

  for (genvar g = 0; g < NumLines; g++) begin : g_lane
    desf_lane u_lane (
      .clk_i     (clk_i),
      .en_i      (load1),
      .line_i    (lines[g]),
      .tc_i      (tc_q),
      .chroma_i  (chroma_q),
      .ctrl_i    (ctrl1_q),
      .line_o    (lane_out[g]),
      .changed_o (lane_chg[g])
    );
  end

  // Merge the lane results into the output register.
  logic [OutBitsW-1:0] merged;
  logic [OutBitsW-1:0] out_q;

  always_comb begin
    merged[OutBitsW-1 -: MaskW] = lane_chg;
    for (int l = 0; l < NumLines; l++) begin
      merged[l*LineOutW +: LineOutW] = lane_out[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      out_q <= merged;
    end
  end

  assign m_axis_tdata_o = {{(OutDataW-OutBitsW){1'b0}}, out_q};

  `DESF_ASSERT(a_stall_holds_input, (v1_q && m_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o, "input taken while pipeline is full and stalled")
  `DESF_ASSERT(a_stage_drains, (v1_q && adv2) |=> m_valid_q, "segment lost between lane stage and output register")
  `DESF_ASSERT(a_out_has_source, $rose(m_valid_q) |-> $past(v1_q), "output became valid with no segment in the lane stage")
  `DESF_ASSERT_RST(a_reset_empty, !rst_ni |=> (!m_axis_tvalid_o && !v1_q), "pipeline not empty after a reset cycle")

endmodule

// ----- verif/deblocking_edge_segment_filter_checker.sv -----
// Checker that predicts and compares every filtered segment of the deblocking filter.
module deblocking_edge_segment_filter_checker
  import desf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Fields from bit 0 up: line_zero, line_one, line_two, line_three.
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  // Fields from bit 0 up: out_line_zero .. out_line_three, changed_mask, zero fill.
  input  logic [OutDataW-1:0] m_tdata_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  error_count_o,
  output int                  outstanding_o
);

  // Shadow copy of the filter settings, updated from the write port.
  logic [BetaW-1:0]    beta_q;
  logic [TcW-1:0]      tc_q;
  logic                chroma_q;
  logic [OutDataW-1:0] predicted_segments_q[$];

  string line_name[NumLines] = '{"out_line_zero", "out_line_one", "out_line_two",
                                 "out_line_three"};

  function automatic int to_byte(input int v);
    return (v < 0) ? 0 : ((v > 255) ? 255 : v);
  endfunction

  function automatic int limit_mag(input int v, input int lim);
    return (v > lim) ? lim : ((v < -lim) ? -lim : v);
  endfunction

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [OutDataW-1:0] filter_segment(input logic [InDataW-1:0] seg,
                                                         input logic [BetaW-1:0] beta_v,
                                                         input logic [TcW-1:0]   tc_v,
                                                         input logic             chroma_v);
    int px[NumLines][6];
    int beta, tc, t2, side, dp0, dq0, dp3, dq3, d;
    int p2, p1, p0, q0, q1, q2;
    int l, k;
    bit ep, eq;
    logic [MaskW-1:0]    mask;
    logic [OutDataW-1:0] res;
    beta = int'(beta_v);
    tc   = int'(tc_v);
    mask = '0;
    res  = '0;
    // Pixel k = 0 is p2 (top byte of the line), k = 5 is q2.
    for (l = 0; l < NumLines; l++) begin
      for (k = 0; k < 6; k++) begin
        px[l][k] = int'(seg[l*LineInW + (5-k)*PixW +: PixW]);
      end
    end
    if (beta != 0 && tc != 0) begin
      if (chroma_v) begin
        for (l = 0; l < NumLines; l++) begin
          d = limit_mag(((px[l][3] - px[l][2]) * 4 + px[l][1] - px[l][4] + 4) >>> 3, tc);
          px[l][2] = to_byte(px[l][2] + d);
          px[l][3] = to_byte(px[l][3] - d);
          mask[l]  = 1'b1;
        end
      end else begin
        dp0  = magnitude(px[0][0] - 2 * px[0][1] + px[0][2]);
        dq0  = magnitude(px[0][5] - 2 * px[0][4] + px[0][3]);
        dp3  = magnitude(px[3][0] - 2 * px[3][1] + px[3][2]);
        dq3  = magnitude(px[3][5] - 2 * px[3][4] + px[3][3]);
        side = (beta + (beta >> 1)) >> 3;
        t2   = tc >> 1;
        if (dp0 + dq0 + dp3 + dq3 < beta) begin
          ep = (dp0 + dp3) < side;
          eq = (dq0 + dq3) < side;
          for (l = 0; l < NumLines; l++) begin
            p2 = px[l][0];
            p1 = px[l][1];
            p0 = px[l][2];
            q0 = px[l][3];
            q1 = px[l][4];
            q2 = px[l][5];
            d  = (9 * (q0 - p0) - 3 * (q1 - p1) + 8) >>> 4;
            // A correction this large marks a real edge, so the line is left alone.
            if (magnitude(d) < tc * 10) begin
              d = limit_mag(d, tc);
              px[l][2] = to_byte(p0 + d);
              px[l][3] = to_byte(q0 - d);
              if (ep) px[l][1] = to_byte(p1 + limit_mag((((p2 + p0 + 1) >> 1) - p1 + d) >>> 1, t2));
              if (eq) px[l][4] = to_byte(q1 + limit_mag((((q2 + q0 + 1) >> 1) - q1 - d) >>> 1, t2));
              mask[l] = 1'b1;
            end
          end
        end
      end
    end
    for (l = 0; l < NumLines; l++) begin
      for (k = 1; k <= 4; k++) begin
        res[l*LineOutW + (4-k)*PixW +: PixW] = PixW'(px[l][k]);
      end
    end
    res[NumLines*LineOutW +: MaskW] = mask;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [OutDataW-1:0] want;
    int l;
    if (!rst_ni) begin
      beta_q        = '0;
      tc_q          = '0;
      chroma_q      = 1'b0;
      predicted_segments_q.delete();
      error_count_o = 0;
      outstanding_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (predicted_segments_q.size() == 0) begin
          $display("%0t: result transfer with nothing outstanding, actual %h", $time, m_tdata_i);
          error_count_o++;
        end else begin
          want = predicted_segments_q.pop_front();
          for (l = 0; l < NumLines; l++) begin
            if (m_tdata_i[l*LineOutW +: LineOutW] !== want[l*LineOutW +: LineOutW]) begin
              $display("%0t: %s expected %h actual %h", $time, line_name[l],
                       want[l*LineOutW +: LineOutW], m_tdata_i[l*LineOutW +: LineOutW]);
              error_count_o++;
            end
          end
          if (m_tdata_i[NumLines*LineOutW +: MaskW] !== want[NumLines*LineOutW +: MaskW]) begin
            $display("%0t: changed_mask expected %h actual %h", $time,
                     want[NumLines*LineOutW +: MaskW], m_tdata_i[NumLines*LineOutW +: MaskW]);
            error_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        predicted_segments_q.push_back(filter_segment(s_tdata_i, beta_q, tc_q, chroma_q));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BETA:   beta_q   = cfg_data_i[BetaW-1:0];
          CFG_TC:     tc_q     = cfg_data_i[TcW-1:0];
          CFG_CHROMA: chroma_q = cfg_data_i[0];
          default:    ;
        endcase
      end
      outstanding_o = predicted_segments_q.size();
    end
  end

endmodule

// ----- verif/deblocking_edge_segment_filter_test.sv -----
// Testbench top that drives segments and settings into the deblocking filter and reports.
module deblocking_edge_segment_filter_test;
  import desf_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int ResetCycles   = 12;
  // The filter holds a segment for two stages, so a few cycles cover any tail.
  localparam int SettleCycles  = 6;
  // Length of the one long receiver hold-off, well beyond the pipeline depth.
  localparam int HoldCycles    = 80;
  localparam int TimeoutCycles = 400000;
  // Register index outside the defined set; writes to it must change nothing.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  int error_count;
  int outstanding;
  // Raised by the stimulus to ask the receiver for its long hold-off.
  bit hold_output = 1'b0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  deblocking_edge_segment_filter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  deblocking_edge_segment_filter_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tdata_i     (s_axis_tdata_i),
    .s_tvalid_i    (s_axis_tvalid_i),
    .s_tready_i    (s_axis_tready_o),
    .m_tdata_i     (m_axis_tdata_o),
    .m_tvalid_i    (m_axis_tvalid_o),
    .m_tready_i    (m_axis_tready_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .error_count_o (error_count),
    .outstanding_o (outstanding)
  );

  // Packs six pixels the way the filter expects them, p2 in the top byte.
  function automatic logic [LineInW-1:0] make_line(input int p2, input int p1, input int p0,
                                                   input int q0, input int q1, input int q2);
    return {p2[7:0], p1[7:0], p0[7:0], q0[7:0], q1[7:0], q2[7:0]};
  endfunction

  // Hand-picked segments that hit the corners of the filter: flat areas, gentle steps both
  // ways, a hard edge, a busy line that kills the activity test, clamping at both ends of the
  // pixel range and a segment where only some lines qualify for filtering.
  function automatic logic [InDataW-1:0] corner_segment(input int idx);
    logic [LineInW-1:0] a, b, c, d;
    case (idx)
      0: begin
        a = make_line(0, 0, 0, 0, 0, 0);
        b = a; c = a; d = a;
      end
      1: begin
        a = make_line(255, 255, 255, 255, 255, 255);
        b = a; c = a; d = a;
      end
      2: begin
        a = make_line(100, 100, 100, 120, 120, 120);
        b = a; c = a; d = a;
      end
      3: begin
        a = make_line(120, 120, 120, 100, 100, 100);
        b = a; c = a; d = a;
      end
      4: begin
        a = make_line(0, 0, 0, 255, 255, 255);
        b = a; c = a; d = a;
      end
      5: begin
        a = make_line(0, 255, 0, 255, 0, 255);
        b = make_line(100, 100, 100, 120, 120, 120);
        c = b; d = b;
      end
      6: begin
        a = make_line(255, 255, 250, 255, 230, 205);
        b = a; c = a; d = a;
      end
      7: begin
        a = make_line(0, 0, 5, 0, 25, 50);
        b = a; c = a; d = a;
      end
      default: begin
        a = make_line(100, 100, 100, 110, 110, 110);
        b = make_line(0, 0, 0, 255, 255, 255);
        c = make_line(80, 82, 84, 70, 68, 66);
        d = a;
      end
    endcase
    return {d, c, b, a};
  endfunction

  // One line following a step across the edge with a slope and a little noise on top.
  function automatic logic [LineInW-1:0] smooth_line(input int lo, input int step,
                                                     input int slope, input int noise);
    logic [LineInW-1:0] line;
    int k, v;
    for (k = 0; k < 6; k++) begin
      v = ((k < 3) ? lo : lo + step) + slope * k + int'($urandom_range(0, 2 * noise)) - noise;
      v = (v < 0) ? 0 : ((v > 255) ? 255 : v);
      line[(5-k)*PixW +: PixW] = v[7:0];
    end
    return line;
  endfunction

  // Most segments are smooth steps so the luma activity test passes and lines get filtered;
  // levels lean toward both ends of the pixel range so that clamping shows up. The rest is
  // plain noise.
  function automatic logic [InDataW-1:0] random_segment();
    logic [InDataW-1:0] seg;
    int lo, step, slope, l, pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      seg = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      case ($urandom_range(0, 3))
        0:       lo = $urandom_range(0, 10);
        1:       lo = $urandom_range(245, 255);
        default: lo = $urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 3))
        0:       step = int'($urandom_range(0, 6)) - 3;
        1:       step = int'($urandom_range(0, 30)) - 15;
        2:       step = int'($urandom_range(0, 80)) - 40;
        default: step = int'($urandom_range(0, 510)) - 255;
      endcase
      slope = int'($urandom_range(0, 4)) - 2;
      for (l = 0; l < NumLines; l++) begin
        // The middle lines are not part of the activity test and may be anything.
        if ((l == 1 || l == 2) && $urandom_range(0, 7) == 0) begin
          seg[l*LineInW +: LineInW] = LineInW'({$urandom, $urandom});
        end else begin
          seg[l*LineInW +: LineInW] = smooth_line(lo, step, slope, $urandom_range(0, 2));
        end
      end
    end
    return seg;
  endfunction

  // Mostly back to back, sometimes a short pause, rarely a long one.
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer, with tvalid
  // still high so that the next segment can follow without a bubble.
  task automatic send_segment(input logic [InDataW-1:0] seg, input int gap);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i  <= seg;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // Stops offering segments and waits until every predicted result has been seen.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Writes all registers, the spare index included. Unused upper data bits carry noise,
  // since only the low bits of each register are meant to be taken.
  task automatic program_filter(input int beta, input int tc, input bit chroma);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgIdxSpare;
    cfg_data_i <= CfgDataW'($urandom);
    @(negedge clk_i);
    cfg_idx_i  <= CFG_BETA;
    cfg_data_i <= beta[BetaW-1:0];
    @(negedge clk_i);
    cfg_idx_i  <= CFG_TC;
    cfg_data_i <= CfgDataW'(($urandom_range(0, 3) << TcW) | tc[TcW-1:0]);
    @(negedge clk_i);
    cfg_idx_i  <= CFG_CHROMA;
    cfg_data_i <= CfgDataW'(($urandom_range(0, 63) << 1) | chroma);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // A run of random segments under the current settings. Halfway through it can ask for the
  // long receiver hold-off while segments keep coming back to back, or pause until the
  // filter is empty.
  task automatic stream_segments(input int count, input bit with_hold, input bit with_pause);
    bit bursty;
    bit pressing;
    int n;
    bursty = ($urandom_range(0, 2) == 0);
    for (n = 0; n < count; n++) begin
      if (n == count / 2) begin
        if (with_hold) hold_output = 1'b1;
        if (with_pause) drain_results();
      end
      pressing = with_hold && n >= count / 2 && n < count / 2 + 30;
      send_segment(random_segment(), (bursty || pressing) ? 0 : sender_gap());
    end
    drain_results();
  endtask

  task automatic run_corner_segments();
    int n;
    for (n = 0; n < 9; n++) begin
      send_segment(corner_segment(n), sender_gap());
    end
    drain_results();
  endtask

  // Receiver: stretches of steady acceptance mixed with stalls, mostly short ones. On
  // request it holds off for a long stretch of its own so the filter fills up and pushes
  // back on its input.
  initial begin : result_sink
    int run_left;
    int r;
    run_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_output) begin
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_output = 1'b0;
        run_left    = 0;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          m_axis_tready_i <= 1'b1;
          run_left = $urandom_range(0, 30);
        end else if (r < 85) begin
          m_axis_tready_i <= 1'b0;
          run_left = $urandom_range(0, 2);
        end else if (r < 95) begin
          m_axis_tready_i <= 1'b0;
          run_left = $urandom_range(3, 8);
        end else begin
          m_axis_tready_i <= 1'b0;
          run_left = $urandom_range(10, 40);
        end
      end
    end
  end

  initial begin : stimulus
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Settings straight out of reset: filtering is off, so every line passes through.
    stream_segments(40, 1'b0, 1'b0);

    // Corner segments under a strong luma setting, a weak one where hard edges are
    // skipped line by line, and chroma.
    program_filter(64, 24, 1'b0);
    run_corner_segments();
    program_filter(64, 2, 1'b0);
    run_corner_segments();
    program_filter(64, 24, 1'b1);
    run_corner_segments();

    // Luma settings, from the top of the range down to the weakest, with beta at
    // zero once to check that it alone turns the filter off.
    program_filter(64, 24, 1'b0);
    stream_segments(90, 1'b1, 1'b0);
    program_filter(127, 31, 1'b0);
    stream_segments(80, 1'b0, 1'b0);
    program_filter(20, 6, 1'b0);
    stream_segments(90, 1'b0, 1'b1);
    program_filter(8, 2, 1'b0);
    stream_segments(70, 1'b0, 1'b0);
    program_filter(1, 1, 1'b0);
    stream_segments(50, 1'b0, 1'b0);
    program_filter(0, 17, 1'b0);
    stream_segments(50, 1'b0, 1'b0);
    program_filter(30, 12, 1'b0);
    stream_segments(90, 1'b0, 1'b0);
    program_filter(127, 1, 1'b0);
    stream_segments(60, 1'b0, 1'b0);
    program_filter(1, 31, 1'b0);
    stream_segments(50, 1'b0, 1'b0);

    // Chroma settings, again with both limits at their extremes.
    program_filter(40, 0, 1'b1);
    stream_segments(50, 1'b0, 1'b0);
    program_filter(64, 24, 1'b1);
    stream_segments(90, 1'b1, 1'b0);
    program_filter(127, 31, 1'b1);
    stream_segments(70, 1'b0, 1'b0);
    program_filter(10, 3, 1'b1);
    stream_segments(70, 1'b0, 1'b0);
    program_filter(1, 1, 1'b1);
    stream_segments(40, 1'b0, 1'b0);
    program_filter(0, 5, 1'b1);
    stream_segments(40, 1'b0, 1'b0);

    // Back to luma after chroma to catch a mode bit that sticks.
    program_filter(45, 9, 1'b0);
    stream_segments(60, 1'b0, 1'b0);

    // Every stream ends by draining, so nothing is outstanding here.
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Ends a run that hangs, for instance on a result that never arrives.
  initial begin : watchdog
    #(TimeoutCycles * ClkPeriod);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
